// ----- rtl/ckx_pkg.sv -----
package ckx_pkg;

    localparam int KLEN_W   = 5;
    localparam int VALUE_W  = 62;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [KLEN_W-1:0] KMER_MAX = 5'd31;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [ADDR_W-3:0] REG_KMER_LENGTH = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Two-bit base codes.
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       start;
        logic       is_base;
        logic [1:0] code;
    } ckx_item_t;

    // Low 2k bits set.
    function automatic logic [VALUE_W-1:0] width_mask(input logic [KLEN_W-1:0] k);
        logic [63:0] ones;
        logic [6:0]  sh;
        ones = '1;
        sh   = 7'd64 - {1'b0, k, 1'b0};
        ones = ones >> sh;
        return ones[VALUE_W-1:0];
    endfunction

    // Reverse complement of a k-base word: base order reversed, each base inverted.
    function automatic logic [VALUE_W-1:0] rev_comp(input logic [VALUE_W-1:0] fwd,
                                                    input logic [KLEN_W-1:0] k);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] s;
        logic [6:0]  sh;
        x = {2'b00, fwd};
        for (int i = 0; i < 32; i++) begin
            r[2*i +: 2] = x[62-2*i +: 2];
        end
        sh = 7'd64 - {1'b0, k, 1'b0};
        s  = (~r) >> sh;
        return s[VALUE_W-1:0];
    endfunction

endpackage

// ----- rtl/ckx_front.sv -----
module ckx_front (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ckx_pkg::CHAR_W-1:0] s_base_char,
    input  logic                       s_record_start,
    input  logic                       queue_full,
    output logic                       push,
    output ckx_pkg::ckx_item_t         item
);

    logic       is_base;
    logic [1:0] code;

    // Map ACGT in either case to two-bit codes; anything else is not a base.
    always_comb begin
        is_base = 1'b1;
        code    = ckx_pkg::BASE_A;
        case (s_base_char) inside
            8'h41, 8'h61: code = ckx_pkg::BASE_A;
            8'h43, 8'h63: code = ckx_pkg::BASE_C;
            8'h47, 8'h67: code = ckx_pkg::BASE_G;
            8'h54, 8'h74: code = ckx_pkg::BASE_T;
            default: begin
                is_base = 1'b0;
                code    = ckx_pkg::BASE_A;
            end
        endcase
    end

    assign s_ready      = !queue_full;
    assign push         = s_valid && !queue_full;
    assign item.start   = s_record_start;
    assign item.is_base = is_base;
    assign item.code    = code;

endmodule

// ----- rtl/ckx_queue.sv -----
module ckx_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ckx_pkg::ckx_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output ckx_pkg::ckx_item_t pop_item
);

    ckx_pkg::ckx_item_t               entries_reg [ckx_pkg::QUEUE_DEPTH];
    logic [ckx_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ckx_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ckx_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full      = (count_reg == ckx_pkg::QCNT_W'(ckx_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/ckx_back.sv -----
module ckx_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ckx_pkg::KLEN_W-1:0]  kmer_length,
    input  logic                        item_avail,
    input  ckx_pkg::ckx_item_t          item,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ckx_pkg::VALUE_W-1:0] m_canonical_value
);

    logic [ckx_pkg::VALUE_W-1:0] window_reg, window_next;
    logic [ckx_pkg::KLEN_W-1:0]  run_reg, run_next;
    logic                        s1_valid_reg, s1_valid_next;
    logic [ckx_pkg::VALUE_W-1:0] s1_fwd_reg;
    logic [ckx_pkg::KLEN_W-1:0]  s1_k_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [ckx_pkg::VALUE_W-1:0] out_value_reg;

    logic [ckx_pkg::KLEN_W-1:0]  k_eff;
    logic [ckx_pkg::VALUE_W-1:0] mask;
    logic [ckx_pkg::VALUE_W-1:0] win_base;
    logic [ckx_pkg::KLEN_W-1:0]  run_base;
    logic [ckx_pkg::KLEN_W-1:0]  run_inc;
    logic                        emit;
    logic                        out_load;
    logic                        s1_load;
    logic [ckx_pkg::VALUE_W-1:0] rc;
    logic [ckx_pkg::VALUE_W-1:0] canon;

    assign k_eff = (kmer_length == '0) ? ckx_pkg::KLEN_W'(1) : kmer_length;
    assign mask  = ckx_pkg::width_mask(k_eff);

    assign out_load = !out_valid_reg || m_ready;
    assign s1_load  = !s1_valid_reg || out_load;
    assign pop      = item_avail && s1_load;

    // Window update; a record start clears the window before its own base.
    always_comb begin
        win_base    = item.start ? '0 : window_reg;
        run_base    = item.start ? '0 : run_reg;
        run_inc     = run_base + 1'b1;
        emit        = 1'b0;
        window_next = window_reg;
        run_next    = run_reg;
        if (pop) begin
            if (!item.is_base) begin
                window_next = '0;
                run_next    = '0;
            end else begin
                window_next = ({win_base[ckx_pkg::VALUE_W-3:0], item.code}) & mask;
                run_next    = run_inc;
                if (run_inc != '0 && run_inc >= k_eff) begin
                    emit     = 1'b1;
                    run_next = k_eff - 1'b1;
                end
            end
        end
        s1_valid_next = s1_load ? emit : s1_valid_reg;
    end

    assign rc    = ckx_pkg::rev_comp(s1_fwd_reg, s1_k_reg);
    assign canon = (s1_fwd_reg < rc) ? s1_fwd_reg : rc;

    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            run_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            window_reg    <= window_next;
            run_reg       <= run_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load && emit) begin
            s1_fwd_reg <= window_next;
            s1_k_reg   <= k_eff;
        end
        if (out_load && s1_valid_reg) begin
            out_value_reg <= canon;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_canonical_value = out_value_reg;

endmodule

// ----- rtl/canonical_kmer_extractor_unit.sv -----
// Canonical k-mer extractor.
// The input channel (s_valid/s_ready) carries one ASCII sequence character per transfer,
// with s_record_start marking the first character of a new record. The output channel
// (m_valid/m_ready) carries one canonical k-mer per transfer: the smaller of the forward
// k-mer and its reverse complement, two bits per base, oldest base in the top bits.
// The k-mer length lives in one register at byte address 0 of the APB-style port and
// should only be changed while no characters are in flight.
// An accepted character passes the queue, the s1 register and the output register before
// its result, if any, shows on m_valid; while the receiver keeps up, the block sustains
// one character per cycle, the window update being one register loop in the back end.
// Reset (aresetn low, synchronous) empties the queue and the pipeline, clears the base
// window and run count, and sets the k-mer length to 31.
// When the receiver stalls, the result holds in the output register, the internal
// stage behind it fills, and the four-entry queue between the classifying front end and
// the back end keeps taking characters until it is full, after which s_ready falls.
module canonical_kmer_extractor_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ckx_pkg::ADDR_W-1:0]  paddr,
    input  logic [ckx_pkg::DATA_W-1:0]  pwdata,
    output logic [ckx_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ckx_pkg::CHAR_W-1:0]  s_base_char,
    input  logic                        s_record_start,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ckx_pkg::VALUE_W-1:0] m_canonical_value
);

    logic [ckx_pkg::KLEN_W-1:0] kmer_length_reg, kmer_length_next;
    logic                       cfg_write;
    logic                       sel_kmer_length;

    logic                       queue_full;
    logic                       queue_push;
    ckx_pkg::ckx_item_t         front_item;
    logic                       queue_not_empty;
    logic                       queue_pop;
    ckx_pkg::ckx_item_t         back_item;

    // The register index is the word address; byte offsets within a word are ignored.
    assign sel_kmer_length = (paddr[ckx_pkg::ADDR_W-1:2] == ckx_pkg::REG_KMER_LENGTH);
    assign cfg_write       = psel && penable && pwrite && pready;
    assign pready          = 1'b1;

    always_comb begin
        kmer_length_next = kmer_length_reg;
        if (cfg_write && sel_kmer_length) begin
            kmer_length_next = pwdata[ckx_pkg::KLEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= ckx_pkg::KMER_MAX;
        end else begin
            kmer_length_reg <= kmer_length_next;
        end
    end

    assign prdata = sel_kmer_length
                  ? {{(ckx_pkg::DATA_W-ckx_pkg::KLEN_W){1'b0}}, kmer_length_reg}
                  : '0;

    // Front end: takes characters and classifies them into base codes.
    ckx_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base_char    (s_base_char),
        .s_record_start (s_record_start),
        .queue_full     (queue_full),
        .push           (queue_push),
        .item           (front_item)
    );

    // Short queue so that each side can stall without holding up the other.
    ckx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (back_item)
    );

    // Back end: window and run count, then the reverse complement and minimum.
    ckx_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .kmer_length       (kmer_length_reg),
        .item_avail        (queue_not_empty),
        .item              (back_item),
        .pop               (queue_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_canonical_value (m_canonical_value)
    );

endmodule

// ----- rtl/ckx_checker.sv -----
module ckx_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        pready,
    input logic [ckx_pkg::DATA_W-1:0]  prdata,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ckx_pkg::VALUE_W-1:0] m_canonical_value
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_canonical_value))
        else $error("result changed or dropped while stalled");

    // Reset leaves the block empty and ready for characters.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

    // Only the five bits of the k-mer length can read back as non-zero.
    a_prdata_width: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[ckx_pkg::DATA_W-1:ckx_pkg::KLEN_W] == '0)
        else $error("unused read data bits set");

endmodule

bind canonical_kmer_extractor_unit ckx_checker u_ckx_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .pready            (pready),
    .prdata            (prdata),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_canonical_value (m_canonical_value)
);

// ----- bench/kmer_check_pkg.sv -----
package kmer_check_pkg;

    import ckx_pkg::*;

    // Tracks the window and run count that the block should hold, and queues the
    // canonical k-mers that it should emit, oldest first.
    class kmer_tracker;

        logic [KLEN_W-1:0]  klen;
        logic [VALUE_W-1:0] window;
        logic [KLEN_W-1:0]  run;
        logic [VALUE_W-1:0] expected_kmers[$];
        int                 faults;
        int                 results_seen;

        function new();
            klen         = KMER_MAX;
            window       = '0;
            run          = '0;
            faults       = 0;
            results_seen = 0;
        endfunction

        function void set_length(logic [DATA_W-1:0] value);
            klen = value[KLEN_W-1:0];
        endfunction

        function logic [5:0] active_k();
            return (klen == '0) ? 6'd1 : {1'b0, klen};
        endfunction

        // Complement every base and reverse their order over the low k bases.
        function logic [VALUE_W-1:0] reverse_complement(logic [VALUE_W-1:0] fwd,
                                                        logic [5:0] k);
            logic [VALUE_W-1:0] acc;
            logic [VALUE_W-1:0] rest;
            acc  = '0;
            rest = fwd;
            for (int i = 0; i < 31; i++) begin
                if (i < k) begin
                    acc  = {acc[VALUE_W-3:0], ~rest[1:0]};
                    rest = rest >> 2;
                end
            end
            return acc;
        endfunction

        function void note_char(logic [CHAR_W-1:0] ch, logic start);
            logic [5:0]         k;
            logic [63:0]        mask;
            logic [63:0]        wide;
            logic [1:0]         code;
            logic               is_base;
            logic [VALUE_W-1:0] fwd;
            logic [VALUE_W-1:0] rc;
            logic [VALUE_W-1:0] canon;
            k    = active_k();
            mask = (64'd1 << (2 * k)) - 64'd1;
            if (start) begin
                window = '0;
                run    = '0;
            end
            is_base = 1'b1;
            case (ch)
                "A", "a": code = BASE_A;
                "C", "c": code = BASE_C;
                "G", "g": code = BASE_G;
                "T", "t": code = BASE_T;
                default: begin
                    code    = BASE_A;
                    is_base = 1'b0;
                end
            endcase
            if (!is_base) begin
                window = '0;
                run    = '0;
                return;
            end
            wide   = (({2'b00, window} << 2) | {62'd0, code}) & mask;
            window = wide[VALUE_W-1:0];
            run    = run + 1'b1;
            if (run == '0 || run < k)
                return;
            run   = k[KLEN_W-1:0] - 1'b1;
            fwd   = window;
            rc    = reverse_complement(fwd, k);
            canon = (fwd < rc) ? fwd : rc;
            expected_kmers.insert(expected_kmers.size(), canon);
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void check_result(logic [VALUE_W-1:0] got);
            logic [VALUE_W-1:0] want;
            results_seen++;
            if (expected_kmers.size() == 0) begin
                note_fault($sformatf("k-mer %h arrived with none outstanding", got));
                return;
            end
            want = expected_kmers.pop_front();
            if (got !== want)
                note_fault($sformatf("k-mer mismatch: expected %h, got %h", want, got));
        endfunction

    endclass

endpackage

// ----- bench/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ckx_pkg::*;
    import kmer_check_pkg::*;

    // Byte addresses on the configuration port. Index one is not mapped, so a
    // write there must leave the length register alone.
    localparam logic [ADDR_W-1:0] LENGTH_ADDR   = ADDR_W'({REG_KMER_LENGTH, 2'b00});
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(4);

    // Cycles with no transfer on either channel before the run is abandoned. The
    // longest legitimate quiet spell is the deliberate receiver hold-off.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER = 300;
    // Cycles allowed for characters that give no k-mer to leave the queue and the
    // pipeline before the length register may be touched.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 195;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_base_char = '0;
    logic               s_record_start = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [VALUE_W-1:0] m_canonical_value;

    kmer_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int chars_sent = 0;
    int settings_done = 0;

    canonical_kmer_extractor_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_base_char       (s_base_char),
        .s_record_start    (s_record_start),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_canonical_value (m_canonical_value)
    );

    initial begin : clock_gen
        forever #6 aclk = ~aclk;
    end

    // Offers one character and waits for its transfer. Any idle cycles are taken
    // before valid is raised, so valid is never dropped while an item is pending,
    // and back-to-back characters keep valid high without a glitch.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_base_char    <= ch;
        s_record_start <= start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_char(ch, start);
        chars_sent++;
    endtask

    // Stops offering characters, waits for every outstanding k-mer, and then gives
    // trailing characters that produce nothing time to drain out of the block.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (tracker.expected_kmers.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // An APB write: a setup phase, then an access phase that completes on pready,
    // then an idle phase on the bus.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // An APB read of the length register; only the register's own bits are compared.
    task automatic apb_check_length();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LENGTH_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata[KLEN_W-1:0] !== tracker.klen)
            tracker.note_fault($sformatf("length read back: expected %0d, got %0d",
                                         tracker.klen, prdata[KLEN_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Changes k only once the block has gone quiet. The window and run count are
    // deliberately kept, so a shorter k can fire on the very next base.
    task automatic change_length(input logic [DATA_W-1:0] value);
        settle_block();
        apb_write(LENGTH_ADDR, value);
        tracker.set_length(value);
        apb_check_length();
        settings_done++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_base();
        logic [CHAR_W-1:0] c;
        case ($urandom_range(3))
            0:       c = "A";
            1:       c = "C";
            2:       c = "G";
            default: c = "T";
        endcase
        // Bit five selects lower case for all four letters.
        if ($urandom_range(1) == 1)
            c = c | 8'h20;
        return c;
    endfunction

    // Random records: mostly bases with a stray character now and then, of lengths
    // up to 2k+40, many long enough to emit plenty of k-mers; some miss their start
    // flag, and one in ten is pure byte noise.
    task automatic run_phase(input int n_items);
        int                sent;
        int                rec_len;
        int                k;
        bit                noisy;
        logic [CHAR_W-1:0] ch;
        logic              start;
        sent = 0;
        k    = (tracker.klen == '0) ? 1 : int'(tracker.klen);
        while (sent < n_items) begin
            rec_len = $urandom_range(2 * k + 40, 1);
            noisy   = ($urandom_range(99) < 10);
            for (int i = 0; i < rec_len && sent < n_items; i++) begin
                if (noisy || $urandom_range(99) < 3)
                    ch = CHAR_W'($urandom_range(255));
                else
                    ch = pick_base();
                if (i == 0)
                    start = ($urandom_range(99) < 90);
                else
                    start = ($urandom_range(199) == 0);
                send_char(ch, start);
                sent++;
            end
        end
    endtask

    // The receiver runs in a process of its own. It checks each transfer on the
    // result channel and draws m_ready afresh every cycle, except for a single long
    // hold-off, counted here, during which the queue inside the block fills and
    // the input channel has to stall.
    initial begin : result_sink
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                tracker.check_result(m_canonical_value);
            if (!held_once && tracker.results_seen >= HOLD_OFF_AFTER) begin
                hold_left = HOLD_OFF_CYCLES;
                held_once = 1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // The watchdog restarts its count on every transfer on either channel.
    initial begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("canonical_kmer_extractor_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int lengths[RANDOM_PHASES];
        lengths = '{31, 1, 17, 0, 5, 30, 2, 12, 31};

        // Synchronous reset, applied once at the start and never repeated.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The length resets to 31; confirm that before any write.
        apb_check_length();

        // Short k with the upper data bits set, which the register must drop.
        change_length(32'hFFFF_FFE3);
        send_char("A", 1'b1);
        send_char("C", 1'b0);
        send_char("G", 1'b0);
        send_char("T", 1'b0);
        send_char("g", 1'b0);
        send_char("t", 1'b0);
        // A stray character empties the window, so two bases are not yet enough.
        send_char("N", 1'b0);
        send_char("c", 1'b0);
        send_char("a", 1'b0);
        send_char(8'h00, 1'b0);
        // A record start on a character that is not a base.
        send_char(8'hFF, 1'b1);
        // All-T forward word, whose reverse complement is all A.
        send_char("T", 1'b0);
        send_char("T", 1'b0);
        send_char("T", 1'b0);
        // A record start restarts the count mid-run, its own base counting as one.
        send_char("G", 1'b1);
        send_char("C", 1'b0);
        send_char("C", 1'b0);

        // A length of zero behaves as a single base.
        change_length(32'd0);
        send_char("A", 1'b0);
        send_char("t", 1'b0);
        send_char("g", 1'b1);
        send_char(8'hC7, 1'b0);

        // A write to the unmapped index must not disturb the length.
        settle_block();
        apb_write(UNMAPPED_ADDR, 32'd5);
        apb_check_length();

        // Build a partial run at full length, then shorten k so that the next base
        // fires at once from the window that is already held.
        change_length(32'h0000_00FF);
        send_char("C", 1'b1);
        send_char("A", 1'b0);
        send_char("T", 1'b0);
        send_char("G", 1'b0);
        send_char("G", 1'b0);
        send_char("A", 1'b0);
        change_length(32'd2);
        send_char("T", 1'b0);

        // Random phases: receiver idles most, then sender idles most, then neither.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 54;
            end else if (p < 6) begin
                send_idle_pct = 54;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            change_length(DATA_W'(lengths[p]) | ($urandom() << KLEN_W));
            run_phase(PHASE_ITEMS);
        end

        settle_block();
        if (tracker.expected_kmers.size() != 0)
            tracker.note_fault($sformatf("%0d k-mers never arrived",
                                         tracker.expected_kmers.size()));

        $display("Run covered %0d characters and %0d checked k-mers over %0d length settings,",
                 chars_sent, tracker.results_seen, settings_done);
        $display("including lengths 0, 1 and 31, record starts, stray bytes and back-pressure.");
        if (tracker.faults == 0) begin
            $display("canonical_kmer_extractor_unit regression: pass");
        end else begin
            $display("canonical_kmer_extractor_unit regression: fail");
        end
        $finish;
    end

endmodule
